@@ src/heq_pkg.sv @@
// ----------------------------------------------------------------------------
// heq_pkg - shared types and constants of the histogram equalizer
// Item format passed from the front queue to the back end, and level constants.
// ----------------------------------------------------------------------------
`default_nettype none

package heq_pkg;

  // Pixel and level geometry.
  localparam int PIX_W     = 8;
  localparam int LEVELS    = 256;
  localparam int TOP_LEVEL = 255;

  // Depth of the queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // Operation carried by a queued item.
  typedef enum logic {
    OP_COUNT = 1'b0,
    OP_MAP   = 1'b1
  } op_t;

  // One classified input item.
  typedef struct packed {
    op_t              op;
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
  } item_t;

endpackage

`default_nettype wire

@@ src/heq_ram.sv @@
// ----------------------------------------------------------------------------
// heq_ram - generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module heq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire  [$clog2(DEPTH)-1:0]  waddr,
  input  wire  [WIDTH-1:0]          wdata,
  input  wire                       re,
  input  wire  [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/heq_front.sv @@
// ----------------------------------------------------------------------------
// heq_front - input acceptance, classification and item queue
// Turns each accepted beat into a count or map item and queues it for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module heq_front (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        s_tvalid,
  output logic                       s_tready,
  input  wire  [7:0]                 s_tdata,   // [7:0] pixel
  input  wire                        s_tlast,
  input  wire                        s_tuser,   // [0] command
  input  wire                        clearing,
  output logic                       avail,
  output heq_pkg::item_t             head,
  input  wire                        pop
);
  import heq_pkg::*;

  item_t           q_mem [Q_DEPTH];
  logic [Q_AW-1:0] wptr;
  logic [Q_AW-1:0] rptr;
  logic [Q_AW:0]   fill;
  logic            push;
  item_t           in_item;

  // Classify the incoming beat; frame end only matters on a count.
  always_comb begin
    in_item.op        = s_tuser ? OP_MAP : OP_COUNT;
    in_item.pixel     = s_tdata;
    in_item.frame_end = s_tlast & ~s_tuser;
  end

  // Accept while there is room and the histogram is not being cleared.
  assign s_tready = (fill != (Q_AW+1)'(Q_DEPTH)) && !clearing;
  assign push     = s_tvalid && s_tready;
  assign avail    = (fill != '0);
  assign head     = q_mem[rptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wptr] <= in_item;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      fill <= fill + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

@@ src/heq_div.sv @@
// ----------------------------------------------------------------------------
// heq_div - restoring divider for one map table entry
// Nine shift-subtract steps give a quotient that is capped at the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module heq_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 24
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  wire  [NUM_W-1:0]  num,
  input  wire  [DEN_W-1:0]  den,
  output logic              done,
  output logic [7:0]        quot
);
  import heq_pkg::*;

  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dsh;
  logic [8:0]       qacc;
  logic [3:0]       step;
  logic             running;
  logic             fits;

  assign fits = (rem >= dsh);
  // A quotient of 256 or more caps at the top level.
  assign quot = qacc[8] ? 8'(TOP_LEVEL) : qacc[7:0];

  // Datapath: one quotient bit per cycle, starting with weight 256.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= NUM_W'(den) << 8;
      qacc <= '0;
      step <= '0;
    end else if (running) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      qacc <= {qacc[7:0], fits};
      dsh  <= dsh >> 1;
      step <= step + 1'b1;
    end
  end

  // Control: run for nine steps, then flag completion for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && step == 4'd8) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/heq_back.sv @@
// ----------------------------------------------------------------------------
// heq_back - histogram, table build and lookup engine
// Executes queued items: counts pixels, builds the level map at frame end and
// answers map lookups through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module heq_back #(
  parameter int MAX_PIXELS_LOG2 = 22
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                avail,
  input  heq_pkg::item_t     head,
  output logic               pop,
  output logic               clearing,
  output logic               m_tvalid,
  input  wire                m_tready,
  output logic [7:0]         m_tdata    // [7:0] mapped_pixel
);
  import heq_pkg::*;

  localparam int CNT_W = MAX_PIXELS_LOG2 + 1;
  localparam int CUM_W = CNT_W + 8;
  localparam int NUM_W = CNT_W + 17;
  localparam int DEN_W = CNT_W + 1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CNT,
    ST_MAP,
    ST_BRD,
    ST_BACC,
    ST_BNUM,
    ST_BDIV,
    ST_BWR
  } state_t;

  state_t            state;
  logic [PIX_W-1:0]  idx;
  logic [CUM_W-1:0]  cum;
  logic [CNT_W-1:0]  total;
  item_t             cur;

  logic              h_we;
  logic [PIX_W-1:0]  h_waddr;
  logic [CNT_W-1:0]  h_wdata;
  logic              h_re;
  logic [PIX_W-1:0]  h_raddr;
  logic [CNT_W-1:0]  h_rdata;
  logic [CNT_W-1:0]  bin_next;
  logic [CNT_W-1:0]  total_next;

  logic              m_we;
  logic [PIX_W-1:0]  m_wdata;
  logic              m_re;
  logic [PIX_W-1:0]  m_rdata;

  logic              div_start;
  logic              div_done;
  logic [7:0]        div_quot;
  logic [NUM_W-1:0]  num;
  logic              out_load;
  logic              last_idx;

  assign clearing = (state == ST_CLEAR);
  assign pop      = (state == ST_IDLE) && avail;
  assign last_idx = (idx == PIX_W'(TOP_LEVEL));
  assign out_load = (state == ST_MAP) && (!m_tvalid || m_tready);

  // Saturating increments of the bin and the frame total.
  assign bin_next   = (h_rdata == '1) ? h_rdata : h_rdata + 1'b1;
  assign total_next = (total == '1) ? total : total + 1'b1;

  // Histogram port control: clear pass, count update, clear during build.
  always_comb begin
    h_re    = (pop && head.op == OP_COUNT) || (state == ST_BRD);
    h_raddr = (state == ST_BRD) ? idx : head.pixel;
    h_we    = (state == ST_CLEAR) || (state == ST_CNT) || (state == ST_BACC);
    h_waddr = (state == ST_CNT) ? cur.pixel : idx;
    h_wdata = (state == ST_CNT) ? bin_next : '0;
  end

  // Level map port control.
  assign m_re    = pop && head.op == OP_MAP;
  assign m_we    = (state == ST_BWR);
  assign m_wdata = (total == '0) ? '0 : div_quot;

  // Numerator 2*255*cum + total, denominator 2*total.
  assign num       = (NUM_W'(cum) << 9) - (NUM_W'(cum) << 1) + NUM_W'(total);
  assign div_start = (state == ST_BNUM);

  heq_ram #(.WIDTH(CNT_W), .DEPTH(LEVELS)) u_hist (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (h_re),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  heq_ram #(.WIDTH(PIX_W), .DEPTH(LEVELS)) u_map (
    .clk   (clk),
    .we    (m_we),
    .waddr (idx),
    .wdata (m_wdata),
    .re    (m_re),
    .raddr (head.pixel),
    .rdata (m_rdata)
  );

  heq_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   ({total, 1'b0}),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Sequencer with its registered state and output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      idx      <= '0;
      total    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= m_rdata;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          idx <= idx + 1'b1;
          if (last_idx) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (avail) begin
            state <= (head.op == OP_MAP) ? ST_MAP : ST_CNT;
          end
        end
        ST_CNT: begin
          total <= total_next;
          if (cur.frame_end) begin
            idx   <= '0;
            state <= ST_BRD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_MAP: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        ST_BRD: begin
          state <= ST_BACC;
        end
        ST_BACC: begin
          state <= ST_BNUM;
        end
        ST_BNUM: begin
          state <= ST_BDIV;
        end
        ST_BDIV: begin
          if (div_done) begin
            state <= ST_BWR;
          end
        end
        ST_BWR: begin
          idx <= idx + 1'b1;
          if (last_idx) begin
            total <= '0;
            state <= ST_IDLE;
          end else begin
            state <= ST_BRD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers: current item and running sum.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (state == ST_CNT) begin
      cum <= '0;
    end else if (state == ST_BACC) begin
      cum <= cum + CUM_W'(h_rdata);
    end
  end

endmodule

`default_nettype wire

@@ src/histogram_equalizer_core.sv @@
// ----------------------------------------------------------------------------
// histogram_equalizer_core - 8-bit grey histogram equalizer
// Counts pixels into a 256-bin histogram, builds a level map at frame end and
// maps pixels through that table.
//
//  Channel | Signals                          | Carries
//  --------+----------------------------------+------------------------------
//  s_*     | tvalid tready tdata tlast tuser  | tdata[7:0] pixel, tuser
//          |                                  | command (0 count, 1 map),
//          |                                  | tlast frame end on a count
//  m_*     | tvalid tready tdata              | tdata[7:0] mapped pixel
//
// A count beat reads its histogram bin in the back end and then writes it back,
// a map beat reads the level map and then waits for the output register.
// A frame end starts a table build of 256 entries, each stepping through read,
// accumulate, numerator, divide and write, with the nine-step divider shared
// by all entries. After reset a clearing pass runs over all 256 histogram
// bins; s_tready is low throughout it. A four-beat queue lets input continue
// while the back end works or the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module histogram_equalizer_core #(
  parameter int MAX_PIXELS_LOG2 = 22
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] pixel
  input  wire         s_tlast,
  input  wire         s_tuser,   // [0] command
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata    // [7:0] mapped_pixel
);
  import heq_pkg::*;

  logic  avail;
  logic  pop;
  logic  clearing;
  item_t head;

  // Front: accept and queue items.
  heq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .clearing (clearing),
    .avail    (avail),
    .head     (head),
    .pop      (pop)
  );

  // Back: execute items.
  heq_back #(.MAX_PIXELS_LOG2(MAX_PIXELS_LOG2)) u_back (
    .clk      (clk),
    .rst      (rst),
    .avail    (avail),
    .head     (head),
    .pop      (pop),
    .clearing (clearing),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

@@ src/heq_checker.sv @@
// ----------------------------------------------------------------------------
// heq_checker - port-level assertions for the histogram equalizer
// Tracks map beats in flight and checks results against them.
// ----------------------------------------------------------------------------
`default_nettype none

module heq_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        s_tuser,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [7:0]  m_tdata
);

  logic [3:0] pending;
  logic       map_in;
  logic       res_out;

  assign map_in  = s_tvalid && s_tready && s_tuser;
  assign res_out = m_tvalid && m_tready;

  // Map beats accepted but not yet answered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 4'(map_in) - 4'(res_out);
    end
  end

  // A result is only shown when a map beat is waiting for it.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != 4'd0)
    else $error("result without an outstanding map beat");

  // Queue, back end and output stage hold at most six map beats.
  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 4'd6)
    else $error("too many map beats in flight");

  // The clearing pass holds off input right after reset.
  a_clear_pass: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("input taken or result shown right after reset");

  // A stalled result holds its data.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind histogram_equalizer_core heq_checker u_heq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the histogram equalizer core
// Streams count and map beats into the core and runs a model of the
// histogram, pixel total and level map alongside it. Every beat on the master
// side is compared with the oldest predicted level. A short directed table
// comes first, followed by random frames. Both sides idle at random until the last third of the random beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import heq_pkg::*;

  localparam int  MAX_PIXELS_LOG2 = 22;
  localparam int  CNT_W           = MAX_PIXELS_LOG2 + 1;
  localparam int  RAND_BEATS      = 800;
  localparam int  NO_LEVEL        = -1;
  localparam int  DIR_ROWS        = 23;
  // Watchdog limit in ns, at a clock period of 12 ns.
  localparam real RUN_LIMIT_NS    = 30_000_000.0;

  // One row of the directed table; a level of NO_LEVEL means the model decides.
  typedef struct {
    op_t        cmd;
    logic [7:0] pix;
    logic       last;
    int         level;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] pixel
  logic       s_tlast = 1'b0;
  logic       s_tuser = 1'b0;    // [0] command
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] mapped_pixel

  // Model state of the core.
  logic [CNT_W-1:0] hist_bins [LEVELS];
  logic [CNT_W-1:0] hist_total;
  logic [7:0]       level_lut [LEVELS];

  logic [7:0] levels_due [$];
  int         err_cnt    = 0;
  int         maps_seen  = 0;
  int         builds     = 0;
  int         src_idle   = 0;
  int         sink_idle  = 0;

  stim_row_t  dir_tab [DIR_ROWS];

  histogram_equalizer_core #(
    .MAX_PIXELS_LOG2(MAX_PIXELS_LOG2)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #6 clk = ~clk;

  // Saturating increment of a histogram counter.
  function automatic logic [CNT_W-1:0] bump_count(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // Builds the level map from the histogram with half-up rounding, then clears it.
  task automatic rebuild_level_lut();
    longint cum;
    longint num;
    longint q;
    cum = 0;
    for (int i = 0; i < LEVELS; i++) begin
      cum += longint'(hist_bins[i]);
      if (hist_total == '0) begin
        level_lut[i] = 8'd0;
      end else begin
        num = 2 * cum * TOP_LEVEL + longint'(hist_total);
        q   = num / (2 * longint'(hist_total));
        level_lut[i] = (q > TOP_LEVEL) ? 8'(TOP_LEVEL) : 8'(q);
      end
    end
    for (int i = 0; i < LEVELS; i++) hist_bins[i] = '0;
    hist_total = '0;
    builds++;
  endtask

  // Applies one accepted beat to the model; a map beat queues its level.
  task automatic apply_beat(input op_t cmd, input logic [7:0] pix, input logic last,
                            input int level);
    if (cmd == OP_MAP) begin
      levels_due = {levels_due, ((level == NO_LEVEL) ? level_lut[pix] : 8'(level))};
    end else begin
      hist_bins[pix] = bump_count(hist_bins[pix]);
      hist_total     = bump_count(hist_total);
      if (last) rebuild_level_lut();
    end
  endtask

  // Presents one beat, holding it until the core takes it. Called at a clock edge.
  task automatic send_beat(input op_t cmd, input logic [7:0] pix, input logic last,
                           input int level);
    if ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= cmd;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_beat(cmd, pix, last, level);
  endtask

  // Output side: random back-pressure and the compare against the model.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        maps_seen++;
        if (levels_due.size() == 0) begin
          $display("%0t unexpected beat: expected none, got %0d", $time, m_tdata);
          err_cnt++;
        end else if (m_tdata !== levels_due[0]) begin
          $display("%0t mapped_pixel mismatch: expected %0d, got %0d",
                   $time, levels_due[0], m_tdata);
          err_cnt++;
          void'(levels_due.pop_front());
        end else begin
          void'(levels_due.pop_front());
        end
      end
      m_tready <= ($urandom_range(99) >= sink_idle);
    end
  end

  // Stimulus: directed table, random frames, drain and verdict.
  initial begin
    int   n_rand;
    int   n_cnt;
    int   n_map;
    int   lo;
    int   hi;
    logic [7:0] pix;

    for (int i = 0; i < LEVELS; i++) begin
      hist_bins[i] = '0;
      level_lut[i] = 8'd0;
    end
    hist_total = '0;

    dir_tab = '{
      // A single pixel at black puts every entry at the top level.
      '{OP_COUNT, 8'h00, 1'b1, NO_LEVEL},
      '{OP_MAP,   8'h00, 1'b0, 255},
      // Frame end on a map beat is ignored.
      '{OP_MAP,   8'hFF, 1'b1, 255},
      // A single pixel at white leaves every lower entry at zero.
      '{OP_COUNT, 8'hFF, 1'b1, NO_LEVEL},
      '{OP_MAP,   8'h00, 1'b0, 0},
      '{OP_MAP,   8'hFE, 1'b0, 0},
      '{OP_MAP,   8'hFF, 1'b0, 255},
      // One black and one white pixel: the lower entries round half up to 128.
      '{OP_COUNT, 8'h00, 1'b0, NO_LEVEL},
      '{OP_COUNT, 8'hFF, 1'b1, NO_LEVEL},
      '{OP_MAP,   8'h00, 1'b0, 128},
      '{OP_MAP,   8'h80, 1'b1, 128},
      '{OP_MAP,   8'hFF, 1'b0, 255},
      // A mixed frame with alternating bit patterns, checked by the model.
      '{OP_COUNT, 8'h55, 1'b0, NO_LEVEL},
      '{OP_COUNT, 8'hAA, 1'b0, NO_LEVEL},
      '{OP_COUNT, 8'h0F, 1'b0, NO_LEVEL},
      '{OP_COUNT, 8'hF0, 1'b0, NO_LEVEL},
      '{OP_COUNT, 8'h80, 1'b0, NO_LEVEL},
      '{OP_MAP,   8'h55, 1'b0, 128},
      '{OP_COUNT, 8'h01, 1'b1, NO_LEVEL},
      '{OP_MAP,   8'h00, 1'b0, NO_LEVEL},
      '{OP_MAP,   8'h01, 1'b0, NO_LEVEL},
      '{OP_MAP,   8'h7F, 1'b1, NO_LEVEL},
      '{OP_MAP,   8'hAA, 1'b0, NO_LEVEL}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle  = 36;
    sink_idle = 76;
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_beat(dir_tab[r].cmd, dir_tab[r].pix, dir_tab[r].last, dir_tab[r].level);
    end

    // Random frames: a skewed histogram, stray maps on the old table, then maps.
    n_rand = 0;
    while (n_rand < RAND_BEATS) begin
      if (n_rand < RAND_BEATS / 3) begin
        src_idle  = 36;
        sink_idle = 76;
      end else if (n_rand < 2 * RAND_BEATS / 3) begin
        src_idle  = 76;
        sink_idle = 36;
      end else begin
        src_idle  = 0;
        sink_idle = 0;
      end
      lo    = $urandom_range(255);
      hi    = $urandom_range(255, lo);
      n_cnt = ($urandom_range(9) == 0) ? $urandom_range(400, 200) : $urandom_range(40, 1);
      // The last frame is cut short so the beat count stays near its target.
      if (n_cnt > RAND_BEATS - n_rand) n_cnt = RAND_BEATS - n_rand;
      for (int k = 0; k < n_cnt; k++) begin
        if ($urandom_range(11) == 0) begin
          send_beat(OP_MAP, 8'($urandom_range(255)), 1'($urandom_range(1)), NO_LEVEL);
          n_rand++;
        end
        pix = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(hi, lo));
        send_beat(OP_COUNT, pix, (k == n_cnt - 1), NO_LEVEL);
        n_rand++;
      end
      n_map = $urandom_range(40, 5);
      for (int k = 0; k < n_map; k++) begin
        send_beat(OP_MAP, 8'($urandom_range(255)), 1'($urandom_range(1)), NO_LEVEL);
        n_rand++;
      end
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    while (levels_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (levels_due.size() != 0) begin
      $display("%0d predicted levels never arrived", levels_due.size());
      err_cnt++;
    end
    $display("Covered %0d directed and %0d random beats, %0d table builds, %0d maps checked.",
             DIR_ROWS, n_rand, builds, maps_seen);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Timeout with %0d levels still pending.", levels_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
